// ===== design/stereo_feedback_delay_core_macros.svh =====
// Assertion macros for the stereo feedback delay core.
// Used by the port checker; expects clk and rst in the enclosing scope.
`ifndef STEREO_FEEDBACK_DELAY_CORE_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sfd_pkg.sv =====
// Shared types and constants of the stereo feedback delay core.
// No dependencies; imported by every design module but the port checker.
package sfd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_TICKS       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_TICK = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_MS         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE_HZ   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIX_AMOUNT       = 3'd6;

  localparam logic MODE_SYNC = 1'b0;
  localparam logic MODE_TIME = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [15:0] feedback;
    logic [16:0] mix;
  } gain_t;

endpackage

// ===== design/sfd_cfg.sv =====
// Configuration registers and delay length computation of the delay core.
// Depends on sfd_pkg.
module sfd_cfg #(
  parameter int DEPTH = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0]   index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]    wdata,
  output logic [$clog2(DEPTH)-1:0]          delay_len,
  output sfd_pkg::gain_t                    gains,
  output logic                              settled
);
  import sfd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [31:0] MS_ROUND     = 32'd500;
  localparam logic [63:0] MS_DIV_MULT  = 64'd2199023256;
  localparam int          MS_DIV_SHIFT = 41;
  localparam logic [1:0]  SETTLE_CYCLES = 2'd3;

  logic        delay_mode;
  logic [6:0]  sync_ticks;
  logic [15:0] samples_per_tick;
  logic [13:0] delay_ms;
  logic [17:0] sample_rate_hz;
  logic [15:0] feedback_gain;
  logic [16:0] mix_amount;
  logic [1:0]  settle_cnt;

  logic [22:0]                sync_prod;
  logic [31:0]                ms_prod;
  logic [63:0]                quot_prod;
  logic [63-MS_DIV_SHIFT:0]   ms_quot;
  logic [31:0]                len_raw;
  logic [AW-1:0]              delay_len_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_mode       <= MODE_SYNC;
      sync_ticks       <= 7'd1;
      samples_per_tick <= 16'd5512;
      delay_ms         <= 14'd250;
      sample_rate_hz   <= 18'd44100;
      feedback_gain    <= 16'd0;
      mix_amount       <= 17'd0;
    end else if (wr_en) begin
      case (index)
        REG_DELAY_MODE:       delay_mode       <= wdata[0];
        REG_SYNC_TICKS:       sync_ticks       <= wdata[6:0];
        REG_SAMPLES_PER_TICK: samples_per_tick <= wdata[15:0];
        REG_DELAY_MS:         delay_ms         <= wdata[13:0];
        REG_SAMPLE_RATE_HZ:   sample_rate_hz   <= wdata[17:0];
        REG_FEEDBACK_GAIN:    feedback_gain    <= wdata[15:0];
        REG_MIX_AMOUNT:       mix_amount       <= wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      settle_cnt <= SETTLE_CYCLES;
    end else if (settle_cnt != 2'd0) begin
      settle_cnt <= settle_cnt - 2'd1;
    end
  end

  assign settled = (settle_cnt == 2'd0);

  // Time mode rounds ms * rate / 1000 by a reciprocal multiply that is exact
  // for every 32-bit dividend.
  assign quot_prod = 64'(ms_prod) * MS_DIV_MULT;

  always_comb begin
    if (delay_mode == MODE_TIME) begin
      len_raw = 32'(ms_quot);
    end else begin
      len_raw = 32'(sync_prod);
    end
    if (len_raw == 32'd0) begin
      delay_len_next = AW'(1);
    end else if (len_raw > 32'(DEPTH - 1)) begin
      delay_len_next = AW'(DEPTH - 1);
    end else begin
      delay_len_next = len_raw[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sync_prod      <= 23'(sync_ticks) * 23'(samples_per_tick);
    ms_prod        <= 32'(delay_ms) * 32'(sample_rate_hz) + MS_ROUND;
    ms_quot        <= quot_prod[63:MS_DIV_SHIFT];
    delay_len      <= delay_len_next;
    gains.feedback <= feedback_gain;
    gains.mix      <= mix_amount[16] ? 17'h10000 : mix_amount;
  end

endmodule

// ===== design/sfd_lane.sv =====
// One channel lane: feedback and crossfade products, then rounding and saturation.
// Depends on sfd_pkg.
module sfd_lane (
  input  logic             clk,
  input  logic             load,
  input  sfd_pkg::sample_t dry,
  input  sfd_pkg::sample_t delayed,
  input  sfd_pkg::gain_t   gains,
  output sfd_pkg::sample_t store_val,
  output sfd_pkg::sample_t out_val
);
  import sfd_pkg::*;

  localparam int ACC_W = 36;
  localparam logic signed [ACC_W-1:0] POS_LIM = 36'sd32767;
  localparam logic signed [ACC_W-1:0] NEG_LIM = -36'sd32768;

  function automatic sample_t sat16(input logic signed [ACC_W-1:0] x);
    sample_t res;
    if (x > POS_LIM) begin
      res = 16'sh7FFF;
    end else if (x < NEG_LIM) begin
      res = 16'sh8000;
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

  logic signed [16:0]      fb_s;
  logic signed [17:0]      mix_s;
  logic signed [16:0]      diff;
  logic signed [32:0]      fb_prod_next;
  logic signed [34:0]      mix_prod_next;
  logic signed [32:0]      fb_prod;
  logic signed [34:0]      mix_prod;
  sample_t                 dry_q;
  logic signed [ACC_W-1:0] bias;
  logic signed [ACC_W-1:0] fb_sum;
  logic signed [ACC_W-1:0] mix_sum;

  always_comb begin
    fb_s          = signed'({1'b0, gains.feedback});
    mix_s         = signed'({1'b0, gains.mix});
    diff          = 17'(delayed) - 17'(dry);
    fb_prod_next  = 33'(delayed) * 33'(fb_s);
    mix_prod_next = 35'(diff) * 35'(mix_s);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fb_prod  <= fb_prod_next;
      mix_prod <= mix_prod_next;
      dry_q    <= dry;
    end
  end

  // The dry sample shifted up by 16 with the rounding half folded in below it.
  always_comb begin
    bias      = ACC_W'(signed'({dry_q, 16'h8000}));
    fb_sum    = ACC_W'(fb_prod) + bias;
    mix_sum   = ACC_W'(mix_prod) + bias;
    store_val = sat16(fb_sum >>> 16);
    out_val   = sat16(mix_sum >>> 16);
  end

endmodule

// ===== design/stereo_feedback_delay_core.sv =====
// Top level of the stereo feedback delay core: delay store, hazard control,
// two channel lanes and the merging output register.
// Depends on sfd_pkg, sfd_cfg and sfd_lane.
//
// Usage: each request on the s_axis side carries one stereo pair of Q1.15
// samples; each request on the m_axis side returns the crossfaded pair. Both
// tdata buses hold left in bits 15:0 and right in bits 31:16.
// Registers are written through cfg_wr_en, cfg_index and cfg_wdata while the
// block is idle; unknown indexes are ignored.
// An accepted input passes the store read register, the lane product
// registers and the output register. Throughput is one pair per cycle when
// the delay length is three samples or more and the receiver does not stall;
// at one or two samples an input waits until the store entry it reads has
// been written back. Reset empties the pipeline and restores the register
// defaults. The delay store is not swept; a write count marks entries never
// written, which read as zero. After reset and after every register write,
// s_axis_tready stays low while the delay length is recomputed.
// When the receiver stalls, the output register holds its result and the two
// internal stages keep filling before s_axis_tready drops.
module stereo_feedback_delay_core #(
  parameter int DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // left_sample, right_sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // left_out, right_out
  input  logic                            cfg_wr_en,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [31:0] store_mem [DEPTH];

  logic [AW-1:0] delay_len;
  gain_t         gains;
  logic          settled;

  logic [AW-1:0] w;
  logic          full;
  logic [AW:0]   diff;
  logic [AW:0]   raddr_w;
  logic [AW-1:0] raddr;
  logic          borrow;
  logic          hazard;

  logic accept;
  logic adv_out;
  logic s2_free;
  logic s1_free;
  logic s1_move;
  logic s2_move;

  logic          v1;
  logic          v2;
  logic          out_valid;
  logic [AW-1:0] s1_waddr;
  logic [AW-1:0] s2_waddr;
  logic          s1_fresh;
  sample_t       s1_dry_l;
  sample_t       s1_dry_r;
  logic [31:0]   rdata;
  logic [31:0]   delayed_word;
  sample_t       store_l;
  sample_t       store_r;
  sample_t       out_l;
  sample_t       out_r;
  logic [31:0]   out_data;

  sfd_cfg #(
    .DEPTH(DEPTH)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .index    (cfg_index),
    .wdata    (cfg_wdata),
    .delay_len(delay_len),
    .gains    (gains),
    .settled  (settled)
  );

  always_comb begin
    diff    = {1'b0, w} - {1'b0, delay_len};
    borrow  = diff[AW];
    raddr_w = borrow ? diff + (AW+1)'(DEPTH) : diff;
    raddr   = raddr_w[AW-1:0];
    hazard  = (v1 && (raddr == s1_waddr)) || (v2 && (raddr == s2_waddr));
  end

  assign adv_out       = !out_valid || m_axis_tready;
  assign s2_free       = !v2 || adv_out;
  assign s2_move       = v2 && adv_out;
  assign s1_free       = !v1 || s2_free;
  assign s1_move       = v1 && s2_free;
  assign s_axis_tready = s1_free && settled && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      w    <= '0;
      full <= 1'b0;
    end else if (accept) begin
      if (w == AW'(DEPTH - 1)) begin
        w    <= '0;
        full <= 1'b1;
      end else begin
        w <= w + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      store_mem[s2_waddr] <= {store_r, store_l};
    end
    if (accept) begin
      rdata <= store_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        v1 <= accept;
      end
      if (s2_free) begin
        v2 <= s1_move;
      end
      if (adv_out) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_waddr <= w;
      s1_fresh <= borrow && !full;
      s1_dry_l <= s_axis_tdata[15:0];
      s1_dry_r <= s_axis_tdata[31:16];
    end
    if (s1_move) begin
      s2_waddr <= s1_waddr;
    end
    if (s2_move) begin
      out_data <= {out_r, out_l};
    end
  end

  assign delayed_word = s1_fresh ? 32'd0 : rdata;

  sfd_lane u_lane_l (
    .clk      (clk),
    .load     (s1_move),
    .dry      (s1_dry_l),
    .delayed  (delayed_word[15:0]),
    .gains    (gains),
    .store_val(store_l),
    .out_val  (out_l)
  );

  sfd_lane u_lane_r (
    .clk      (clk),
    .load     (s1_move),
    .dry      (s1_dry_r),
    .delayed  (delayed_word[31:16]),
    .gains    (gains),
    .store_val(store_r),
    .out_val  (out_r)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== design/sfd_checker.sv =====
// Port-level checker for the stereo feedback delay core, bound to the top level.
// Depends on stereo_feedback_delay_core_macros.svh.
`include "stereo_feedback_delay_core_macros.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        cfg_wr_en
);

  `SFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output request changed while stalled")

  `SFD_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr_en, !s_axis_tready, "input ready right after a register write")

  `SFD_ASSERT_IMPL(a_reset_empty, $past(rst), !m_axis_tvalid && !s_axis_tready, "block not empty after reset")

endmodule

bind stereo_feedback_delay_core sfd_checker u_sfd_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the stereo feedback delay core.
// Predicts each output pair from its own echo store model; depends on sfd_pkg
// and stereo_feedback_delay_core.
`timescale 1ns / 1ps

module tb_top;
  import sfd_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int PIPE_LAT    = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS  = 20;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    sample_t right;
    sample_t left;
  } pair_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata;   // left_sample, right_sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [31:0]            m_axis_tdata;   // left_out, right_out
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bit [31:0]   echo_mem [DEPTH];
  int unsigned wr_ptr;
  bit          mode_q;
  bit [6:0]    ticks_q;
  bit [15:0]   spt_q;
  bit [13:0]   ms_q;
  bit [17:0]   rate_q;
  bit [15:0]   fb_q;
  bit [16:0]   mix_q;

  pair_t       pending_out [$];
  int unsigned errors        = 0;
  int unsigned sent_pairs    = 0;
  int unsigned checked_pairs = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  bit          send_steady   = 0;
  bit          recv_steady   = 0;

  stereo_feedback_delay_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_cnt,
               pending_out.size());
      $display("stereo_feedback_delay_core: mismatch");
      $finish;
    end
  end

  function automatic int unsigned delay_samples();
    longint d;
    if (mode_q == MODE_SYNC) d = longint'(ticks_q) * longint'(spt_q);
    else d = (longint'(ms_q) * longint'(rate_q) + 500) / 1000;
    if (d < 1) d = 1;
    if (d > DEPTH - 1) d = DEPTH - 1;
    return int'(d);
  endfunction

  function automatic longint q16_round(longint p);
    longint t;
    t = p + 32768;
    return t >>> 16;
  endfunction

  function automatic sample_t clip16(longint x);
    if (x > 32767) return sample_t'(16'h7FFF);
    if (x < -32768) return sample_t'(16'h8000);
    return sample_t'(x);
  endfunction

  function automatic sample_t feed_sum(sample_t dry, sample_t dly);
    return clip16(longint'(dry) + q16_round(longint'(dly) * longint'(fb_q)));
  endfunction

  function automatic sample_t wet_mix(sample_t dry, sample_t dly);
    longint m;
    m = (mix_q > 17'd65536) ? 65536 : longint'(mix_q);
    return clip16(longint'(dry) + q16_round((longint'(dly) - longint'(dry)) * m));
  endfunction

  function automatic void step_echo(sample_t l, sample_t r);
    int unsigned rd;
    bit [31:0]   word;
    sample_t     yl;
    sample_t     yr;
    pair_t       res;
    rd = (wr_ptr + DEPTH - delay_samples()) % DEPTH;
    word = echo_mem[rd];
    yl = word[15:0];
    yr = word[31:16];
    echo_mem[wr_ptr] = {feed_sum(r, yr), feed_sum(l, yl)};
    wr_ptr = (wr_ptr + 1) % DEPTH;
    res.left  = wet_mix(l, yl);
    res.right = wet_mix(r, yr);
    pending_out.push_back(res);
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_DELAY_MODE:       mode_q  = v[0];
      REG_SYNC_TICKS:       ticks_q = v[6:0];
      REG_SAMPLES_PER_TICK: spt_q   = v[15:0];
      REG_DELAY_MS:         ms_q    = v[13:0];
      REG_SAMPLE_RATE_HZ:   rate_q  = v[17:0];
      REG_FEEDBACK_GAIN:    fb_q    = v[15:0];
      REG_MIX_AMOUNT:       mix_q   = v[16:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_echo_model();
    foreach (echo_mem[i]) echo_mem[i] = '0;
    wr_ptr  = 0;
    mode_q  = MODE_SYNC;
    ticks_q = 7'd1;
    spt_q   = 16'd5512;
    ms_q    = 14'd250;
    rate_q  = 18'd44100;
    fb_q    = '0;
    mix_q   = '0;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return sample_t'(16'h7FFF);
      1: return sample_t'(16'h8000);
      2: return sample_t'(0);
      3: return sample_t'(16'hFFFF);
      4: return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("ERROR cycle %0d: %s expected %0d got %0d", cycle_cnt, what, want, got);
  endtask

  task automatic check_result(pair_t got);
    pair_t want;
    if (pending_out.size() == 0) begin
      report_mismatch("output pair with no request pending", 0, got.left);
      return;
    end
    want = pending_out.pop_front();
    checked_pairs++;
    if (got.left !== want.left) report_mismatch("left_out", want.left, got.left);
    if (got.right !== want.right) report_mismatch("right_out", want.right, got.right);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // The receiver alone drives m_axis_tready; a requested hold-off is counted here.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= recv_steady || ($urandom_range(99) >= 27);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(sample_t l, sample_t r);
    while (!send_steady && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r, l};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    step_echo(l, r);
    sent_pairs++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 3) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    apply_reg(idx, value[CFG_DATA_W-1:0]);
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(bit mode, int unsigned ticks, int unsigned spt,
                           int unsigned ms, int unsigned rate, int unsigned fb,
                           int unsigned mix);
    write_reg(REG_DELAY_MODE, mode);
    write_reg(REG_SYNC_TICKS, ticks);
    write_reg(REG_SAMPLES_PER_TICK, spt);
    write_reg(REG_DELAY_MS, ms);
    write_reg(REG_SAMPLE_RATE_HZ, rate);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_MIX_AMOUNT, mix);
  endtask

  task automatic random_setting();
    bit          mode;
    int unsigned kind;
    int unsigned ticks;
    int unsigned spt;
    int unsigned ms;
    int unsigned rate;
    int unsigned fb;
    int unsigned mix;
    mode  = $urandom_range(1);
    kind  = $urandom_range(9);
    ticks = $urandom_range(127);
    spt   = $urandom_range(65535);
    ms    = $urandom_range(16383);
    rate  = $urandom_range(262143);
    if (mode == MODE_SYNC && kind < 6) begin
      ticks = $urandom_range(4);
      spt   = $urandom_range(12);
    end else if (mode == MODE_SYNC && kind < 9) begin
      ticks = $urandom_range(1, 16);
      spt   = $urandom_range(1, 64);
    end else if (mode == MODE_TIME && kind < 6) begin
      ms   = $urandom_range(2);
      rate = $urandom_range(6000);
    end else if (mode == MODE_TIME && kind < 9) begin
      ms   = $urandom_range(1, 20);
      rate = $urandom_range(8000, 48000);
    end
    case ($urandom_range(3))
      0: fb = 0;
      1: fb = 62259;
      2: fb = 65535;
      default: fb = $urandom_range(65535);
    endcase
    case ($urandom_range(4))
      0: mix = 0;
      1: mix = 65536;
      2: mix = 131071;
      3: mix = $urandom_range(65536);
      default: mix = $urandom_range(131071);
    endcase
    write_all(mode, ticks, spt, ms, rate, fb, mix);
  endtask

  task automatic test_reset_defaults();
    send_pair(sample_t'(16'h7FFF), sample_t'(16'h8000));
    send_pair(sample_t'(16'h8000), sample_t'(16'h7FFF));
    send_pair(sample_t'(0), sample_t'(-1));
    send_pair(sample_t'(1), sample_t'(0));
  endtask

  task automatic test_directed_edges();
    // Zero tick count, feedback above 0.95 and mix above unity; the store saturates.
    write_all(MODE_SYNC, 0, 5, 250, 44100, 65535, 131071);
    repeat (3) send_pair(sample_t'(16'h7FFF), sample_t'(16'h7FFF));
    repeat (3) send_pair(sample_t'(16'h8000), sample_t'(16'h8000));
    // Zero milliseconds at the highest rate gives the shortest delay.
    write_all(MODE_TIME, 1, 0, 0, 262143, 62259, 32768);
    send_pair(sample_t'(16'h8000), sample_t'(16'h7FFF));
    send_pair(sample_t'(16'h7FFF), sample_t'(16'h8000));
    send_pair(sample_t'(-1), sample_t'(1));
    send_pair(sample_t'(100), sample_t'(-100));
    send_pair(sample_t'(0), sample_t'(0));
    // Overlong time delay clamps to the end of the store.
    write_all(MODE_TIME, 127, 65535, 16383, 262143, 0, 65536);
    repeat (3) send_pair(pick_sample(), pick_sample());
    // A write to an unused index must change nothing.
    write_reg(REG_SPARE, 32'h3FFFF);
    write_all(MODE_SYNC, 127, 65535, 1, 8000, 1, 1);
    repeat (3) send_pair(pick_sample(), pick_sample());
    write_all(MODE_TIME, 1, 1, 1, 2000, 40000, 20000);
    repeat (3) send_pair(pick_sample(), pick_sample());
  endtask

  task automatic test_random_phases(int unsigned phases, int unsigned per_phase);
    repeat (phases) begin
      random_setting();
      repeat (per_phase) send_pair(pick_sample(), pick_sample());
    end
  endtask

  task automatic test_full_rate();
    write_all(MODE_SYNC, 4, 8, 100, 48000, 40000, 30000);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    repeat (200) send_pair(pick_sample(), pick_sample());
    send_steady = 1'b0;
    recv_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    write_all(MODE_TIME, 1, 1, 3, 16000, 50000, 45000);
    send_steady = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (90) send_pair(pick_sample(), pick_sample());
    send_steady = 1'b0;
  endtask

  task automatic finish_run();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (PIPE_LAT * 4) @(negedge clk);
    $display("Checked %0d of %0d stereo requests across %0d register writes.",
             checked_pairs, sent_pairs, reg_writes);
    $display("Covered both delay modes, delays 1..%0d, saturation, stalls and hold-off.",
             DEPTH - 1);
    if (errors == 0) begin
      $display("stereo_feedback_delay_core: match");
    end else begin
      $display("stereo_feedback_delay_core: mismatch");
    end
    $finish;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    reset_echo_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_edges();
    test_random_phases(10, 110);
    test_full_rate();
    test_backpressure();
    finish_run();
  end

endmodule

// ===== files.f =====
+incdir+design
design/sfd_pkg.sv
design/sfd_cfg.sv
design/sfd_lane.sv
design/stereo_feedback_delay_core.sv
design/sfd_checker.sv
verif/tb_top.sv
